### hdl/tiled_maze_escape_search_assert.svh
// Assertion macros shared by the maze search RTL.
`ifndef TILED_MAZE_ESCAPE_SEARCH_ASSERT_SVH
`define TILED_MAZE_ESCAPE_SEARCH_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define TMES_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// A condition that must hold in the cycle after a trigger.
`define TMES_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence violated");

`endif

### hdl/tmes_pkg.sv
// Types, constants and helper functions of the tiled maze escape search.
package tmes_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int CELL_SLOTS = MAX_ROWS * MAX_COLS;
   localparam int CELL_W     = $clog2(CELL_SLOTS);
   localparam int DEPTH_W    = CELL_W + 1;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int DIM_W      = 7;
   localparam int TILE_W     = 16;
   localparam int DIR_W      = 3;
   localparam int CSR_IDX_W  = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 4'd1;

   // Step directions: right, left, down, up, then exhausted.
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

   typedef struct packed {
      logic [DIM_W-1:0]   rows;
      logic [DIM_W-1:0]   cols;
      logic [DEPTH_W-1:0] size;
   } dims_type;

   typedef struct packed {
      logic              wall;
      logic              visited;
      logic [TILE_W-1:0] trow;
      logic [TILE_W-1:0] tcol;
   } cell_type;

   typedef struct packed {
      logic [ROW_W-1:0]  r;
      logic [COL_W-1:0]  c;
      logic [TILE_W-1:0] trow;
      logic [TILE_W-1:0] tcol;
      logic [DIR_W-1:0]  dir;
   } frame_type;

   // Clamp a dimension register into 1..maxv.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = 7'd1;
      end else if (v > maxv) begin
         res = maxv;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

### hdl/tiled_maze_escape_search.sv
// Top level of the tiled maze escape search: configuration registers and ports.
//
// Usage. Write row_count (index 0) and col_count (index 1) on the csr_ port,
// which is always ready. Then send the maze one cell per word on req_, in
// row-major order, with start; a word is taken when start is high and busy
// is low. Cells load at one word per cycle while busy is low. The word with
// req_last_cell set ends the grid: without a start cell the verdict appears
// on rsp_ in the next cycle with rsp_start_missing set. Otherwise the start
// position is split into row and column by a divider run twice, then the
// start cell is seeded, then the search tests each neighbor through the
// states STEP, ADDR and CHECK and backtracks through STEP and POPRD.
// rsp_valid pulses for one cycle with the verdict; the receiver cannot
// stall. A pass over every grid cell then clears the visited marks, with
// busy high. After reset busy stays high while the whole cell memory is
// cleared; configuration writes are taken during that time.
module tiled_maze_escape_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_is_wall,
   input  logic                              req_is_start,
   input  logic                              req_last_cell,
   output logic                              rsp_valid,
   output logic                              rsp_can_escape,
   output logic                              rsp_start_missing,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tmes_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tmes_pkg::DIM_W-1:0]        csr_data
);

   logic [tmes_pkg::DIM_W-1:0] row_count_ff, row_count_in;
   logic [tmes_pkg::DIM_W-1:0] col_count_ff, col_count_in;
   tmes_pkg::dims_type         dims;
   logic                       search_busy;

   // Configuration register writes.
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_valid) begin
         case (csr_index)
            tmes_pkg::CSR_ROW_COUNT: row_count_in = csr_data;
            tmes_pkg::CSR_COL_COUNT: col_count_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 7'd1;
         col_count_ff <= 7'd1;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // Effective grid dimensions and cell count.
   always_comb begin
      dims.rows = tmes_pkg::clamp_dim(row_count_ff, tmes_pkg::DIM_W'(tmes_pkg::MAX_ROWS));
      dims.cols = tmes_pkg::clamp_dim(col_count_ff, tmes_pkg::DIM_W'(tmes_pkg::MAX_COLS));
      dims.size = tmes_pkg::DEPTH_W'(dims.rows * dims.cols);
   end

   tmes_search u_search (
      .clock             (clock),
      .reset             (reset),
      .dims              (dims),
      .load_en           (start && !search_busy),
      .load_wall         (req_is_wall),
      .load_start        (req_is_start),
      .load_last         (req_last_cell),
      .busy              (search_busy),
      .rsp_valid         (rsp_valid),
      .rsp_can_escape    (rsp_can_escape),
      .rsp_start_missing (rsp_start_missing)
   );

   assign busy      = search_busy;
   assign csr_ready = 1'b1;

endmodule

### hdl/tmes_div.sv
// Restoring divider that splits a cell position into quotient and remainder.
module tmes_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [tmes_pkg::CELL_W-1:0]    dividend,
   input  logic [tmes_pkg::DIM_W-1:0]     divisor,
   output logic                           done,
   output logic [tmes_pkg::CELL_W-1:0]    quotient,
   output logic [tmes_pkg::DIM_W-1:0]     remainder
);

   logic [tmes_pkg::CELL_W-1:0] quo_ff, quo_in;
   logic [tmes_pkg::DIM_W-1:0]  rem_ff, rem_in;
   logic [tmes_pkg::DIM_W-1:0]  dvs_ff, dvs_in;
   logic [3:0]                  cnt_ff, cnt_in;
   logic                        act_ff, act_in;
   logic                        done_ff, done_in;
   logic [tmes_pkg::DIM_W:0]    trial;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      act_in  = act_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[tmes_pkg::CELL_W-1]};
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         act_in = 1'b1;
      end else if (act_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = tmes_pkg::DIM_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[tmes_pkg::CELL_W-2:0], 1'b1};
         end else begin
            rem_in = trial[tmes_pkg::DIM_W-1:0];
            quo_in = {quo_ff[tmes_pkg::CELL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(tmes_pkg::CELL_W - 1)) begin
            act_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hdl/tmes_search.sv
// Cell memory, search stack memory, loader and depth-first search sequencer.
`include "tiled_maze_escape_search_assert.svh"

module tmes_search (
   input  logic               clock,
   input  logic               reset,
   input  tmes_pkg::dims_type dims,
   input  logic               load_en,
   input  logic               load_wall,
   input  logic               load_start,
   input  logic               load_last,
   output logic               busy,
   output logic               rsp_valid,
   output logic               rsp_can_escape,
   output logic               rsp_start_missing
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RSTCLR = 4'd1;
   localparam logic [3:0] ST_GO1    = 4'd2;
   localparam logic [3:0] ST_WAIT1  = 4'd3;
   localparam logic [3:0] ST_GO2    = 4'd4;
   localparam logic [3:0] ST_WAIT2  = 4'd5;
   localparam logic [3:0] ST_SADDR  = 4'd6;
   localparam logic [3:0] ST_SWRITE = 4'd7;
   localparam logic [3:0] ST_STEP   = 4'd8;
   localparam logic [3:0] ST_ADDR   = 4'd9;
   localparam logic [3:0] ST_CHECK  = 4'd10;
   localparam logic [3:0] ST_POPRD  = 4'd11;
   localparam logic [3:0] ST_CLEAR  = 4'd12;
   localparam logic [3:0] ST_CLRLST = 4'd13;

   localparam int CW = tmes_pkg::CELL_W;
   localparam int DW = tmes_pkg::DEPTH_W;
   localparam int RW = tmes_pkg::ROW_W;
   localparam int KW = tmes_pkg::COL_W;
   localparam int TW = tmes_pkg::TILE_W;

   tmes_pkg::cell_type  cell_mem [tmes_pkg::CELL_SLOTS];
   tmes_pkg::frame_type stk_mem  [tmes_pkg::CELL_SLOTS];

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       load_pos_ff, load_pos_in;
   logic [CW-1:0]       start_pos_ff, start_pos_in;
   logic                start_ok_ff, start_ok_in;
   logic [DW-1:0]       depth_ff, depth_in;
   tmes_pkg::frame_type top_ff, top_in;
   logic [RW-1:0]       nb_r_ff, nb_r_in;
   logic [KW-1:0]       nb_c_ff, nb_c_in;
   logic [TW-1:0]       nb_tr_ff, nb_tr_in;
   logic [TW-1:0]       nb_tc_ff, nb_tc_in;
   logic [RW-1:0]       srow_ff, srow_in;
   logic [KW-1:0]       scol_ff, scol_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [DW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]       clr_wa_ff, clr_wa_in;
   logic                clr_pend_ff, clr_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_esc_ff, rsp_esc_in;
   logic                rsp_miss_ff, rsp_miss_in;

   tmes_pkg::cell_type  cell_rd_ff;
   tmes_pkg::frame_type stk_rd_ff;

   logic                cell_we;
   logic [CW-1:0]       cell_wa;
   tmes_pkg::cell_type  cell_wd;
   logic [CW-1:0]       cell_ra;
   logic                stk_we;
   logic [CW-1:0]       stk_wa;
   tmes_pkg::frame_type stk_wd;
   logic [CW-1:0]       stk_ra;

   logic                div_go;
   logic [CW-1:0]       div_dividend;
   logic [tmes_pkg::DIM_W-1:0] div_divisor;
   logic                div_done;
   logic [CW-1:0]       div_quo;
   logic [tmes_pkg::DIM_W-1:0] div_rem;

   logic [RW-1:0]       mul_r;
   logic [KW-1:0]       mul_c;
   logic [CW:0]         mul_idx;
   logic [CW-1:0]       pos;
   logic [CW:0]         pos_next;
   logic [tmes_pkg::DIM_W-1:0] c_inc;
   logic [tmes_pkg::DIM_W-1:0] r_inc;
   logic [DW-1:0]       depth_dec;
   logic [DW-1:0]       depth_dec2;

   tmes_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Row-major cell index of a row and column.
   assign mul_r   = (state_ff == ST_SADDR) ? srow_ff : nb_r_ff;
   assign mul_c   = (state_ff == ST_SADDR) ? scol_ff : nb_c_ff;
   assign mul_idx = mul_r * dims.cols + mul_c;

   // Load slot of the current word, wrapped into the grid.
   assign pos      = ({1'b0, load_pos_ff} >= dims.size) ? '0 : load_pos_ff;
   assign pos_next = {1'b0, pos} + 1'b1;

   assign c_inc      = {1'b0, top_ff.c} + 1'b1;
   assign r_inc      = {1'b0, top_ff.r} + 1'b1;
   assign depth_dec  = depth_ff - 1'b1;
   assign depth_dec2 = depth_ff - 2'd2;

   // Sequencer for loading, start setup, search steps and clearing passes.
   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      start_pos_in = start_pos_ff;
      start_ok_in  = start_ok_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      nb_r_in      = nb_r_ff;
      nb_c_in      = nb_c_ff;
      nb_tr_in     = nb_tr_ff;
      nb_tc_in     = nb_tc_ff;
      srow_in      = srow_ff;
      scol_in      = scol_ff;
      idx_in       = idx_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_wa_in    = clr_wa_ff;
      clr_pend_in  = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_esc_in   = rsp_esc_ff;
      rsp_miss_in  = rsp_miss_ff;
      cell_we      = 1'b0;
      cell_wa      = idx_ff;
      cell_wd      = '0;
      cell_ra      = mul_idx[CW-1:0];
      stk_we       = 1'b0;
      stk_wa       = depth_dec[CW-1:0];
      stk_wd       = top_ff;
      stk_ra       = depth_dec2[CW-1:0];
      div_go       = 1'b0;
      div_dividend = start_pos_ff;
      div_divisor  = dims.cols;

      case (state_ff)
         ST_RSTCLR: begin
            cell_we    = 1'b1;
            cell_wa    = clr_cnt_ff[CW-1:0];
            cell_wd    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == DW'(tmes_pkg::CELL_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (load_en) begin
               cell_we      = 1'b1;
               cell_wa      = pos;
               cell_wd.wall = load_wall;
               if (!load_wall && load_start) begin
                  start_pos_in = pos;
                  start_ok_in  = 1'b1;
               end
               load_pos_in = (pos_next >= dims.size) ? '0 : pos_next[CW-1:0];
               if (load_last) begin
                  load_pos_in = '0;
                  start_ok_in = 1'b0;
                  if (start_ok_ff || (!load_wall && load_start)) begin
                     state_in = ST_GO1;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_esc_in   = 1'b0;
                     rsp_miss_in  = 1'b1;
                  end
               end
            end
         end
         ST_GO1: begin
            div_go   = 1'b1;
            state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (div_done) begin
               scol_in  = div_rem[KW-1:0];
               state_in = ST_GO2;
            end
         end
         ST_GO2: begin
            div_go       = 1'b1;
            div_dividend = div_quo;
            div_divisor  = dims.rows;
            state_in     = ST_WAIT2;
         end
         ST_WAIT2: begin
            if (div_done) begin
               srow_in  = div_rem[RW-1:0];
               state_in = ST_SADDR;
            end
         end
         ST_SADDR: begin
            idx_in   = mul_idx[CW-1:0];
            state_in = ST_SWRITE;
         end
         ST_SWRITE: begin
            // The start keeps its wall bit; only neighbors are tested.
            cell_we         = 1'b1;
            cell_wd.wall    = cell_rd_ff.wall;
            cell_wd.visited = 1'b1;
            top_in          = '0;
            top_in.r        = srow_ff;
            top_in.c        = scol_ff;
            depth_in        = DW'(1);
            state_in        = ST_STEP;
         end
         ST_STEP: begin
            nb_r_in  = top_ff.r;
            nb_c_in  = top_ff.c;
            nb_tr_in = top_ff.trow;
            nb_tc_in = top_ff.tcol;
            case (top_ff.dir)
               tmes_pkg::DIR_RIGHT: begin
                  if (c_inc >= dims.cols) begin
                     nb_c_in  = '0;
                     nb_tc_in = top_ff.tcol + 1'b1;
                  end else begin
                     nb_c_in = c_inc[KW-1:0];
                  end
               end
               tmes_pkg::DIR_LEFT: begin
                  if (top_ff.c == '0) begin
                     nb_c_in  = KW'(dims.cols - 1'b1);
                     nb_tc_in = top_ff.tcol - 1'b1;
                  end else begin
                     nb_c_in = top_ff.c - 1'b1;
                  end
               end
               tmes_pkg::DIR_DOWN: begin
                  if (r_inc >= dims.rows) begin
                     nb_r_in  = '0;
                     nb_tr_in = top_ff.trow + 1'b1;
                  end else begin
                     nb_r_in = r_inc[RW-1:0];
                  end
               end
               tmes_pkg::DIR_UP: begin
                  if (top_ff.r == '0) begin
                     nb_r_in  = RW'(dims.rows - 1'b1);
                     nb_tr_in = top_ff.trow - 1'b1;
                  end else begin
                     nb_r_in = top_ff.r - 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (top_ff.dir >= tmes_pkg::DIR_DONE) begin
               // Frame exhausted: pop it.
               depth_in = depth_dec;
               if (depth_ff == DW'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_esc_in   = 1'b0;
                  rsp_miss_in  = 1'b0;
                  clr_cnt_in   = '0;
                  state_in     = ST_CLEAR;
               end else begin
                  state_in = ST_POPRD;
               end
            end else begin
               top_in.dir = top_ff.dir + 1'b1;
               state_in   = ST_ADDR;
            end
         end
         ST_ADDR: begin
            idx_in   = mul_idx[CW-1:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_STEP;
            if (cell_rd_ff.wall) begin
               state_in = ST_STEP;
            end else if (cell_rd_ff.visited) begin
               if (cell_rd_ff.trow != nb_tr_ff || cell_rd_ff.tcol != nb_tc_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_esc_in   = 1'b1;
                  rsp_miss_in  = 1'b0;
                  clr_cnt_in   = '0;
                  state_in     = ST_CLEAR;
               end
            end else begin
               cell_we         = 1'b1;
               cell_wd.visited = 1'b1;
               cell_wd.trow    = nb_tr_ff;
               cell_wd.tcol    = nb_tc_ff;
               if (depth_ff >= DW'(tmes_pkg::CELL_SLOTS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_esc_in   = 1'b0;
                  rsp_miss_in  = 1'b0;
                  clr_cnt_in   = '0;
                  state_in     = ST_CLEAR;
               end else begin
                  // Push: the old top goes to memory, the neighbor becomes top.
                  stk_we      = 1'b1;
                  top_in.r    = nb_r_ff;
                  top_in.c    = nb_c_ff;
                  top_in.trow = nb_tr_ff;
                  top_in.tcol = nb_tc_ff;
                  top_in.dir  = tmes_pkg::DIR_RIGHT;
                  depth_in    = depth_ff + 1'b1;
               end
            end
         end
         ST_POPRD: begin
            top_in   = stk_rd_ff;
            state_in = ST_STEP;
         end
         ST_CLEAR: begin
            // Read one cell per cycle and write it back unvisited in the cycle after.
            cell_ra     = clr_cnt_ff[CW-1:0];
            clr_wa_in   = clr_cnt_ff[CW-1:0];
            clr_pend_in = 1'b1;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == dims.size - 1'b1) begin
               state_in = ST_CLRLST;
            end
            cell_we      = clr_pend_ff;
            cell_wa      = clr_wa_ff;
            cell_wd.wall = cell_rd_ff.wall;
         end
         ST_CLRLST: begin
            cell_we      = clr_pend_ff;
            cell_wa      = clr_wa_ff;
            cell_wd.wall = cell_rd_ff.wall;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RSTCLR;
         load_pos_ff  <= '0;
         start_ok_ff  <= 1'b0;
         depth_ff     <= '0;
         clr_cnt_ff   <= '0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         start_ok_ff  <= start_ok_in;
         depth_ff     <= depth_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      start_pos_ff <= start_pos_in;
      top_ff       <= top_in;
      nb_r_ff      <= nb_r_in;
      nb_c_ff      <= nb_c_in;
      nb_tr_ff     <= nb_tr_in;
      nb_tc_ff     <= nb_tc_in;
      srow_ff      <= srow_in;
      scol_ff      <= scol_in;
      idx_ff       <= idx_in;
      clr_wa_ff    <= clr_wa_in;
      rsp_esc_ff   <= rsp_esc_in;
      rsp_miss_ff  <= rsp_miss_in;
   end

   // Cell memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      cell_rd_ff <= cell_mem[cell_ra];
   end

   // Stack memory holding every frame below the top.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_can_escape    = rsp_esc_ff;
   assign rsp_start_missing = rsp_miss_ff;

   `TMES_ASSERT_ALWAYS(a_depth_bound, clock, reset, depth_ff <= DW'(tmes_pkg::CELL_SLOTS))
   `TMES_ASSERT_ALWAYS(a_step_nonempty, clock, reset, state_ff != ST_STEP || depth_ff != '0)
   `TMES_ASSERT_ALWAYS(a_load_idle, clock, reset, !load_en || state_ff == ST_IDLE)
   `TMES_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff && !rsp_miss_ff, !rsp_valid_ff)

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the tiled maze escape search block.
module testbench;
   import tmes_pkg::*;

   // One verdict word as it leaves the block.
   typedef struct packed {
      logic can_escape;
      logic start_missing;
   } verdict_type;

   // Tracks maze state, predicts each verdict and checks what the block returns.
   class maze_scoreboard;
      bit               wall_map [CELL_SLOTS];
      bit               seen     [CELL_SLOTS];
      bit [TILE_W-1:0]  seen_trow[CELL_SLOTS];
      bit [TILE_W-1:0]  seen_tcol[CELL_SLOTS];
      int               stk_cell [CELL_SLOTS];
      bit [TILE_W-1:0]  stk_trow [CELL_SLOTS];
      bit [TILE_W-1:0]  stk_tcol [CELL_SLOTS];
      int               stk_dir  [CELL_SLOTS];
      bit [DIM_W-1:0]   row_reg = 1;
      bit [DIM_W-1:0]   col_reg = 1;
      int               load_pos = 0;
      int               start_pos = 0;
      bit               start_seen = 0;
      verdict_type      verdicts[$];
      int               mismatches = 0;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
         if (idx == CSR_ROW_COUNT) row_reg = val;
         else if (idx == CSR_COL_COUNT) col_reg = val;
      endfunction

      function int eff_rows();
         return (row_reg == 0) ? 1 : (row_reg > MAX_ROWS) ? MAX_ROWS : row_reg;
      endfunction

      function int eff_cols();
         return (col_reg == 0) ? 1 : (col_reg > MAX_COLS) ? MAX_COLS : col_reg;
      endfunction

      // Depth-first walk over the endlessly repeated maze.
      function bit escapes(int rows, int cols);
         int depth, top, cur, r, c, d, nxt;
         bit [TILE_W-1:0] tr, tc;
         cur = start_pos % (rows * cols);
         seen[cur] = 1;
         seen_trow[cur] = 0;
         seen_tcol[cur] = 0;
         stk_cell[0] = cur;
         stk_trow[0] = 0;
         stk_tcol[0] = 0;
         stk_dir[0] = DIR_RIGHT;
         depth = 1;
         while (depth > 0) begin
            top = depth - 1;
            cur = stk_cell[top];
            r = cur / cols;
            c = cur % cols;
            tr = stk_trow[top];
            tc = stk_tcol[top];
            d = stk_dir[top];
            if (d >= DIR_DONE) begin
               depth--;
               continue;
            end
            stk_dir[top] = d + 1;
            case (d)
               DIR_RIGHT: if (c + 1 >= cols) begin c = 0; tc++; end else c++;
               DIR_LEFT:  if (c == 0) begin c = cols - 1; tc--; end else c--;
               DIR_DOWN:  if (r + 1 >= rows) begin r = 0; tr++; end else r++;
               default:   if (r == 0) begin r = rows - 1; tr--; end else r--;
            endcase
            nxt = r * cols + c;
            if (wall_map[nxt]) continue;
            if (seen[nxt]) begin
               if (seen_trow[nxt] == tr && seen_tcol[nxt] == tc) continue;
               return 1;
            end
            seen[nxt] = 1;
            seen_trow[nxt] = tr;
            seen_tcol[nxt] = tc;
            if (depth >= CELL_SLOTS) return 0;
            stk_cell[depth] = nxt;
            stk_trow[depth] = tr;
            stk_tcol[depth] = tc;
            stk_dir[depth] = DIR_RIGHT;
            depth++;
         end
         return 0;
      endfunction

      // Loads one accepted cell word; the last cell of a grid yields a verdict.
      function void note_cell(bit w, bit s, bit l);
         int rows, cols, size;
         verdict_type v;
         rows = eff_rows();
         cols = eff_cols();
         size = rows * cols;
         if (load_pos >= size) load_pos = 0;
         wall_map[load_pos] = w;
         if (!w && s) begin
            start_pos = load_pos;
            start_seen = 1;
         end
         load_pos++;
         if (load_pos >= size) load_pos = 0;
         if (!l) return;
         if (start_seen) begin
            v.can_escape = escapes(rows, cols);
            v.start_missing = 0;
         end else begin
            v.can_escape = 0;
            v.start_missing = 1;
         end
         verdicts.push_back(v);
         foreach (seen[i]) seen[i] = 0;
         load_pos = 0;
         start_seen = 0;
         start_pos = 0;
      endfunction

      // Compares a returned verdict with the oldest prediction.
      function void check_verdict(logic esc, logic miss);
         verdict_type want;
         if (verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected verdict: can_escape=%0b start_missing=%0b", esc, miss);
            return;
         end
         want = verdicts.pop_front();
         if (want.can_escape !== esc || want.start_missing !== miss) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Verdict mismatch: expected can_escape=%0b start_missing=%0b, got %0b %0b",
                        want.can_escape, want.start_missing, esc, miss);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_is_wall;
   logic                 req_is_start;
   logic                 req_last_cell;
   logic                 rsp_valid;
   logic                 rsp_can_escape;
   logic                 rsp_start_missing;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_data;

   maze_scoreboard       board;
   int                   cells_sent;
   int                   cycle_count = 0;

   localparam int CLEAR_WAIT  = 4300;
   localparam int CYCLE_LIMIT = 4000000;

   tiled_maze_escape_search i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_is_wall(req_is_wall), .req_is_start(req_is_start),
      .req_last_cell(req_last_cell), .rsp_valid(rsp_valid),
      .rsp_can_escape(rsp_can_escape), .rsp_start_missing(rsp_start_missing),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Verdicts are checked at the edge that ends their single valid cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_verdict(rsp_can_escape, rsp_start_missing);
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Writes one register and mirrors it in the scoreboard.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      board.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Sends one cell word after a random gap; start stays high into the next word.
   task automatic send_cell(bit w, bit s, bit l);
      int gap;
      gap = $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         start <= 0;
      end
      @(negedge clock);
      start         <= 1;
      req_is_wall   <= w;
      req_is_start  <= s;
      req_last_cell <= l;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      board.note_cell(w, s, l);
      cells_sent++;
   endtask

   // Holds the sender off until every verdict is in and the clearing pass is over.
   task automatic drain;
      @(negedge clock);
      start <= 0;
      while (board.verdicts.size() > 0) @(posedge clock);
      repeat (CLEAR_WAIT) @(posedge clock);
   endtask

   task automatic set_dims(int rows, int cols);
      drain();
      write_reg(CSR_ROW_COUNT, DIM_W'(rows));
      write_reg(CSR_COL_COUNT, DIM_W'(cols));
   endtask

   // One grid: mostly a well-formed maze, sometimes a broken or noisy one.
   task automatic send_grid(int density);
      int size, len, spot;
      bit w;
      size = board.eff_rows() * board.eff_cols();
      if ($urandom_range(0, 99) < 75) begin
         spot = $urandom_range(0, size - 1);
         for (int i = 0; i < size; i++) begin
            w = (i == spot) ? 0 : ($urandom_range(0, 99) < density);
            send_cell(w, i == spot, i == size - 1);
         end
      end else begin
         len = $urandom_range(1, size + 3);
         for (int i = 0; i < len; i++)
            send_cell($urandom_range(0, 99) < density, $urandom_range(0, 9) == 0,
                      i == len - 1);
      end
   endtask

   initial begin
      int rows, cols, grids;
      board = new;
      cells_sent = 0;
      reset = 1;
      start = 0;
      req_is_wall = 0;
      req_is_start = 0;
      req_last_cell = 0;
      csr_valid = 0;
      csr_index = CSR_ROW_COUNT;
      csr_data = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Single cell: open start escapes at once; a walled start or none is missing.
      send_cell(0, 1, 1);
      send_cell(1, 1, 1);
      send_cell(0, 0, 1);
      // A start covered by a walled second start word, then a grid cut short.
      set_dims(0, 0);
      send_cell(0, 1, 0);
      send_cell(1, 1, 1);
      set_dims(2, 2);
      send_cell(0, 0, 0);
      send_cell(0, 1, 1);
      // Overflowing grid whose start is then covered by a wall.
      send_cell(0, 1, 0);
      send_cell(0, 0, 0);
      send_cell(1, 0, 0);
      send_cell(1, 0, 0);
      send_cell(1, 0, 1);
      // Walls all around the start: no escape.
      set_dims(3, 3);
      for (int i = 0; i < 9; i++) send_cell(i != 4, i == 4, i == 8);

      // Size extremes; the largest grid is cut short to keep the run small.
      set_dims(127, 1);
      send_grid(20);
      set_dims(1, 127);
      send_grid(20);
      set_dims(64, 64);
      for (int i = 0; i < 150; i++)
         send_cell((i != 70) && ($urandom_range(0, 99) < 25), i == 70, i == 149);

      // Random phases, mostly small mazes.
      while (cells_sent < 750) begin
         case ($urandom_range(0, 9))
            0: begin rows = $urandom_range(0, 127); cols = $urandom_range(0, 3); end
            1: begin rows = $urandom_range(0, 3); cols = $urandom_range(65, 127); end
            default: begin rows = $urandom_range(1, 8); cols = $urandom_range(1, 8); end
         endcase
         set_dims(rows, cols);
         grids = $urandom_range(3, 8);
         repeat (grids) send_grid($urandom_range(5, 60));
      end

      drain();
      if (board.mismatches == 0 && board.verdicts.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
